@@ design/fra_pkg.sv @@
// fra_pkg: request codes, record types and fixed constants of the fenced ring allocator
// used by fenced_ring_allocator; depends on nothing else
package fra_pkg;

    // request and response kinds
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FINISH  = 2'd1;
    localparam logic [1:0] REQ_RELEASE = 2'd2;

    // most freed frames reported by one release request
    localparam int unsigned RESULT_LIMIT = 16;
    localparam int unsigned REL_CNT_W    = $clog2(RESULT_LIMIT + 1);

    // ring size after reset
    localparam logic [31:0] RING_SIZE_RESET = 32'd65536;

    // one queued frame record
    typedef struct packed {
        logic [63:0] fence;
        logic [31:0] tail;
        logic [31:0] bytes;
    } frame_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic        alloc_ok;
        logic [31:0] alloc_offset;
        logic        frame_queued;
        logic        frame_released;
        logic [63:0] released_fence;
        logic [31:0] released_tail;
        logic [31:0] released_bytes;
        logic        last;
    } resp_t;

endpackage

@@ design/fenced_ring_allocator.sv @@
// fenced_ring_allocator: ring buffer allocator with a queue of fenced frame records
// depends on fra_pkg for request codes, record types and constants
//
// Usage:
//   Requests arrive on the s_ channel (valid/ready): allocate, finish frame or
//   release completed frames. Results leave on the m_ channel (valid/ready),
//   with m_last marking the final result of a request. The ring size register
//   is written through cfg_wr_en/cfg_wr_data; the user must write it only
//   while the block is idle, the block itself does not enforce this. One
//   request is handled at a time. An allocate runs a fit check, then the
//   saturating used/open byte update; a finish is handled on acceptance; a
//   release pops frames until it reaches a frame whose fence is still ahead,
//   with a registered frame record read and a fence compare on that data.
//   A result is visible on the m_ side in the cycle after it is produced.
//   A two-entry output queue lets the next request be taken while a result
//   still waits; when it is full, s_ready drops and release stops popping
//   frames until the receiver takes a result.
//   Reset (aresetn low, synchronous) empties the ring, the frame queue and the
//   output queue and sets the ring size to 65536; frame records are not
//   cleared, only entries that were written are ever read.
module fenced_ring_allocator #(
    parameter int FRAME_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_alloc_size,
    input  logic [63:0] s_fence_value,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_resp_kind,
    output logic        m_alloc_ok,
    output logic [31:0] m_alloc_offset,
    output logic        m_frame_queued,
    output logic        m_frame_released,
    output logic [63:0] m_released_fence,
    output logic [31:0] m_released_tail,
    output logic [31:0] m_released_bytes,
    output logic        m_last
);

    localparam int PTR_W = $clog2(FRAME_SLOTS);
    localparam int CNT_W = $clog2(FRAME_SLOTS + 1);
    localparam int REL_CNT_W = fra_pkg::REL_CNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FRAME_SLOTS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FRAME_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_ALLOC    = 5'b00010,
        ST_REL_READ = 5'b00100,
        ST_REL_EVAL = 5'b01000,
        ST_REL_DONE = 5'b10000
    } state_t;

    // control and ring state
    state_t           state_reg, state_next;
    logic [31:0]      ring_size_reg, ring_size_next;
    logic [31:0]      head_reg, head_next;
    logic [31:0]      tail_reg, tail_next;
    logic [31:0]      used_reg, used_next;
    logic [31:0]      open_reg, open_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] qcount_reg, qcount_next;
    logic [REL_CNT_W-1:0] rel_n_reg, rel_n_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [1:0]       ocount_reg, ocount_next;

    // payload registers
    logic             grant_ok_reg, grant_ok_next;
    logic [31:0]      grant_off_reg, grant_off_next;
    logic [31:0]      grant_skip_reg, grant_skip_next;
    logic [31:0]      grant_size_reg, grant_size_next;
    logic [63:0]      rel_fence_reg, rel_fence_next;
    fra_pkg::frame_t  pend_frame_reg, pend_frame_next;
    fra_pkg::resp_t   oq0_reg, oq0_next;
    fra_pkg::resp_t   oq1_reg, oq1_next;

    // frame record memory
    fra_pkg::frame_t  frame_mem [FRAME_SLOTS];
    fra_pkg::frame_t  rd_frame_reg;
    logic             mem_we;
    fra_pkg::frame_t  mem_wdata;

    // combinational helpers
    logic             accept;
    logic             pop;
    logic             push;
    logic             can_push;
    fra_pkg::resp_t   push_data;
    logic [32:0]      tail_plus;
    logic [33:0]      used_sum;
    logic [33:0]      open_sum;
    logic             qualifies;
    logic [CNT_W-1:0] qcount_dec;
    logic [REL_CNT_W-1:0] rel_n_inc;

    assign s_ready  = (state_reg == ST_IDLE) && (ocount_reg != 2'd2);
    assign accept   = s_valid && s_ready;
    assign m_valid  = (ocount_reg != 2'd0);
    assign pop      = m_valid && m_ready;
    assign can_push = (ocount_reg != 2'd2);

    assign m_resp_kind      = oq0_reg.kind;
    assign m_alloc_ok       = oq0_reg.alloc_ok;
    assign m_alloc_offset   = oq0_reg.alloc_offset;
    assign m_frame_queued   = oq0_reg.frame_queued;
    assign m_frame_released = oq0_reg.frame_released;
    assign m_released_fence = oq0_reg.released_fence;
    assign m_released_tail  = oq0_reg.released_tail;
    assign m_released_bytes = oq0_reg.released_bytes;
    assign m_last           = oq0_reg.last;

    assign tail_plus  = {1'b0, tail_reg} + {1'b0, s_alloc_size};
    assign used_sum   = {2'b00, used_reg} + {2'b00, grant_skip_reg} + {2'b00, grant_size_reg};
    assign open_sum   = {2'b00, open_reg} + {2'b00, grant_skip_reg} + {2'b00, grant_size_reg};
    assign qualifies  = (rd_frame_reg.fence <= rel_fence_reg);
    assign qcount_dec = qcount_reg - CNT_W'(1);
    assign rel_n_inc  = rel_n_reg + REL_CNT_W'(1);

    // request sequencer
    always_comb begin
        state_next      = state_reg;
        ring_size_next  = ring_size_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        open_next       = open_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        qcount_next     = qcount_reg;
        rel_n_next      = rel_n_reg;
        pend_valid_next = pend_valid_reg;
        grant_ok_next   = grant_ok_reg;
        grant_off_next  = grant_off_reg;
        grant_skip_next = grant_skip_reg;
        grant_size_next = grant_size_reg;
        rel_fence_next  = rel_fence_reg;
        pend_frame_next = pend_frame_reg;
        mem_we          = 1'b0;
        mem_wdata       = '{fence: s_fence_value, tail: tail_reg, bytes: open_reg};
        push            = 1'b0;
        push_data       = '0;

        if (cfg_wr_en) begin
            ring_size_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_req_type)
                        fra_pkg::REQ_ALLOC: begin
                            // fit check; byte accounting follows in the next cycle
                            grant_ok_next   = 1'b0;
                            grant_off_next  = '0;
                            grant_skip_next = '0;
                            grant_size_next = '0;
                            if (used_reg != ring_size_reg) begin
                                if (tail_reg >= head_reg) begin
                                    if (tail_plus <= {1'b0, ring_size_reg}) begin
                                        grant_ok_next   = 1'b1;
                                        grant_off_next  = tail_reg;
                                        grant_size_next = s_alloc_size;
                                        tail_next       = tail_plus[31:0];
                                    end else if (s_alloc_size <= head_reg) begin
                                        // wrap to zero, skipped end space counts as used
                                        grant_ok_next   = 1'b1;
                                        grant_size_next = s_alloc_size;
                                        grant_skip_next = (ring_size_reg > tail_reg) ?
                                                          ring_size_reg - tail_reg : '0;
                                        tail_next       = s_alloc_size;
                                    end
                                end else if (tail_plus <= {1'b0, head_reg}) begin
                                    grant_ok_next   = 1'b1;
                                    grant_off_next  = tail_reg;
                                    grant_size_next = s_alloc_size;
                                    tail_next       = tail_plus[31:0];
                                end
                            end
                            state_next = ST_ALLOC;
                        end
                        fra_pkg::REQ_FINISH: begin
                            // close the open frame into the record queue when it has a free slot
                            push           = 1'b1;
                            push_data.kind = fra_pkg::REQ_FINISH;
                            push_data.last = 1'b1;
                            if (qcount_reg < CNT_FULL) begin
                                mem_we                 = 1'b1;
                                wr_ptr_next            = (wr_ptr_reg == PTR_LAST) ?
                                                         '0 : wr_ptr_reg + PTR_W'(1);
                                qcount_next            = qcount_reg + CNT_W'(1);
                                open_next              = '0;
                                push_data.frame_queued = 1'b1;
                            end
                        end
                        fra_pkg::REQ_RELEASE: begin
                            rel_fence_next  = s_fence_value;
                            rel_n_next      = '0;
                            pend_valid_next = 1'b0;
                            state_next      = (qcount_reg != '0) ? ST_REL_READ : ST_REL_DONE;
                        end
                        default: begin
                            // unused request code: no result
                        end
                    endcase
                end
            end
            ST_ALLOC: begin
                if (can_push) begin
                    push                   = 1'b1;
                    push_data.kind         = fra_pkg::REQ_ALLOC;
                    push_data.alloc_ok     = grant_ok_reg;
                    push_data.alloc_offset = grant_off_reg;
                    push_data.last         = 1'b1;
                    if (grant_ok_reg) begin
                        used_next = (used_sum[33:32] != 2'b00) ? '1 : used_sum[31:0];
                        open_next = (open_sum[33:32] != 2'b00) ? '1 : open_sum[31:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_REL_READ: begin
                // record at the read pointer lands in rd_frame_reg
                state_next = ST_REL_EVAL;
            end
            ST_REL_EVAL: begin
                if (!qualifies) begin
                    state_next = ST_REL_DONE;
                end else if (!pend_valid_reg || can_push) begin
                    // hand on the previous freed frame, it was not the last one
                    if (pend_valid_reg) begin
                        push                     = 1'b1;
                        push_data.kind           = fra_pkg::REQ_RELEASE;
                        push_data.frame_released = 1'b1;
                        push_data.released_fence = pend_frame_reg.fence;
                        push_data.released_tail  = pend_frame_reg.tail;
                        push_data.released_bytes = pend_frame_reg.bytes;
                    end
                    // pop this frame
                    used_next       = (rd_frame_reg.bytes <= used_reg) ?
                                      used_reg - rd_frame_reg.bytes : '0;
                    head_next       = rd_frame_reg.tail;
                    rd_ptr_next     = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
                    qcount_next     = qcount_dec;
                    rel_n_next      = rel_n_inc;
                    pend_frame_next = rd_frame_reg;
                    pend_valid_next = 1'b1;
                    state_next      = ((qcount_dec != '0) &&
                                       (rel_n_inc != REL_CNT_W'(fra_pkg::RESULT_LIMIT))) ?
                                      ST_REL_READ : ST_REL_DONE;
                end
            end
            ST_REL_DONE: begin
                // final release result: last freed frame or an empty one
                if (can_push) begin
                    push                     = 1'b1;
                    push_data.kind           = fra_pkg::REQ_RELEASE;
                    push_data.frame_released = pend_valid_reg;
                    push_data.last           = 1'b1;
                    if (pend_valid_reg) begin
                        push_data.released_fence = pend_frame_reg.fence;
                        push_data.released_tail  = pend_frame_reg.tail;
                        push_data.released_bytes = pend_frame_reg.bytes;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // two-entry output queue
    always_comb begin
        oq0_next    = oq0_reg;
        oq1_next    = oq1_reg;
        ocount_next = ocount_reg;
        case ({push, pop})
            2'b10: begin
                if (ocount_reg == 2'd0) begin
                    oq0_next = push_data;
                end else begin
                    oq1_next = push_data;
                end
                ocount_next = ocount_reg + 2'd1;
            end
            2'b01: begin
                oq0_next    = oq1_reg;
                ocount_next = ocount_reg - 2'd1;
            end
            2'b11: begin
                if (ocount_reg == 2'd1) begin
                    oq0_next = push_data;
                end else begin
                    oq0_next = oq1_reg;
                    oq1_next = push_data;
                end
            end
            default: begin
                ocount_next = ocount_reg;
            end
        endcase
    end

    // frame record memory, registered read at the read pointer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[wr_ptr_reg] <= mem_wdata;
        end
        rd_frame_reg <= frame_mem[rd_ptr_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            ring_size_reg  <= fra_pkg::RING_SIZE_RESET;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            open_reg       <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            qcount_reg     <= '0;
            rel_n_reg      <= '0;
            pend_valid_reg <= 1'b0;
            ocount_reg     <= '0;
        end else begin
            state_reg      <= state_next;
            ring_size_reg  <= ring_size_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            used_reg       <= used_next;
            open_reg       <= open_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            qcount_reg     <= qcount_next;
            rel_n_reg      <= rel_n_next;
            pend_valid_reg <= pend_valid_next;
            ocount_reg     <= ocount_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        grant_ok_reg   <= grant_ok_next;
        grant_off_reg  <= grant_off_next;
        grant_skip_reg <= grant_skip_next;
        grant_size_reg <= grant_size_next;
        rel_fence_reg  <= rel_fence_next;
        pend_frame_reg <= pend_frame_next;
        oq0_reg        <= oq0_next;
        oq1_reg        <= oq1_next;
    end

    // the frame queue never holds more records than slots
    assert property (@(posedge aclk) disable iff (!aresetn)
        qcount_reg <= CNT_FULL)
        else $error("frame queue count beyond slot count");

    // a record is only evaluated while the queue holds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_REL_EVAL) |-> (qcount_reg != '0))
        else $error("release evaluates an empty queue");

    // a freed frame result always belongs to a release request
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_released) |-> (m_resp_kind == fra_pkg::REQ_RELEASE))
        else $error("freed frame on a non-release result");

    // an accepted allocate moves on to its accounting step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_req_type == fra_pkg::REQ_ALLOC)) |=> (state_reg == ST_ALLOC))
        else $error("allocate did not enter accounting step");

    // a release never reports more frames than the result limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        rel_n_reg <= REL_CNT_W'(fra_pkg::RESULT_LIMIT))
        else $error("release freed too many frames");

endmodule
